### src/mmcs_pkg.sv
// shared constants, types and helpers of the min/max contrast stretch
// no dependencies
package mmcs_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int SAMPLE_W = 32;
	localparam int GREY_W = 8;
	localparam int SCALE_ROUNDS = 7;
	localparam int STEP_COUNT = 2 * SCALE_ROUNDS;
	localparam int CNT_W = $clog2(STEP_COUNT);
	localparam int COPY_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [GREY_W-1:0] GREY_MAX = {GREY_W{1'b1}};

	// operation codes of an input item
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	typedef logic [SAMPLE_BITS-1:0] word_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_WB   = 4'b1000
	} state_t;

	typedef struct packed {
		logic measure;
		logic load;
		logic prep;
		logic step;
		logic add_phase;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic need_div;
	} status_t;

	// low bits of the sample, sign extended when the word is wider
	function automatic word_t to_word(input logic [SAMPLE_W-1:0] s);
		word_t w;
		w = '0;
		for (int i = 0; i < COPY_BITS; i++) begin
			w[i] = s[i];
		end
		for (int i = COPY_BITS; i < SAMPLE_BITS; i++) begin
			w[i] = s[SAMPLE_W-1];
		end
		return w;
	endfunction

endpackage

### src/min_max_contrast_stretch.sv
// min/max contrast stretch to 8-bit grey levels, top level
// measure item: no result, ready again the next cycle
// convert item: result registered at writeback after the 14 steps of the serial
// scaler; prepare goes straight to writeback when the range is zero or the sample lies at or outside its bounds
// the next item is taken once the convert item is written back, later on a stalled result
// reset (arst_n low, asynchronous) clears min/max to zero and empties the output
module min_max_contrast_stretch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [mmcs_pkg::SAMPLE_W-1:0] sample,
	input  logic                          first,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mmcs_pkg::GREY_W-1:0]   grey,
	output logic                          flat
);
	import mmcs_pkg::*;

	cmd_t    cmd;
	status_t status;

	mmcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mmcs_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.first  (first),
		.cmd    (cmd),
		.status (status),
		.grey   (grey),
		.flat   (flat)
	);

endmodule

### src/mmcs_ctrl.sv
// controller: sequences measure, prepare, division steps and writeback
// depends on mmcs_pkg
module mmcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             operation,
	output logic             out_valid,
	input  logic             out_ready,
	input  mmcs_pkg::status_t status,
	output mmcs_pkg::cmd_t    cmd
);
	import mmcs_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.measure = (operation == OP_MEASURE);
					cmd.load = (operation == OP_CONVERT);
					if (operation == OP_CONVERT) begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = status.need_div ? ST_DIV : ST_WB;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cmd.add_phase = cnt_q[0];
				if (cnt_q == CNT_W'(STEP_COUNT - 1)) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				if (!out_valid_q || out_ready) begin
					cmd.wb = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.wb) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/mmcs_datapath.sv
// datapath: running min/max, range classification, serial 255/range scaler
// depends on mmcs_pkg
module mmcs_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mmcs_pkg::SAMPLE_W-1:0] sample,
	input  logic                          first,
	input  mmcs_pkg::cmd_t                cmd,
	output mmcs_pkg::status_t             status,
	output logic [mmcs_pkg::GREY_W-1:0]   grey,
	output logic                          flat
);
	import mmcs_pkg::*;

	word_t              in_word;
	word_t              low_q;
	word_t              high_q;
	word_t              s_q;
	word_t              num_q;
	word_t              div_q;
	word_t              rem_q;
	logic [GREY_W-1:0]  quo_q;
	logic [GREY_W-1:0]  sat_q;
	logic               need_div_q;
	logic               flat_pre_q;
	logic [GREY_W-1:0]  grey_q;
	logic               flat_q;

	logic               is_flat;
	logic               is_below;
	logic               is_above;
	word_t              addend;
	logic [SAMPLE_BITS:0] sum;
	logic               carry;
	word_t              rem_next;

	assign in_word = to_word(sample);

	// range classification of the captured convert item
	assign is_flat  = !($signed(high_q) > $signed(low_q));
	assign is_below = ($signed(s_q) <= $signed(low_q));
	assign is_above = ($signed(s_q) >= $signed(high_q));
	assign status.need_div = !is_flat && !is_below && !is_above;

	// one modular add per step: doubling or adding the numerator
	assign addend   = cmd.add_phase ? num_q : rem_q;
	assign sum      = {1'b0, rem_q} + {1'b0, addend};
	assign carry    = (sum >= {1'b0, div_q});
	assign rem_next = carry ? SAMPLE_BITS'(sum - {1'b0, div_q}) : sum[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			high_q <= '0;
		end else if (cmd.measure) begin
			if (first) begin
				low_q <= in_word;
				high_q <= in_word;
			end else begin
				if ($signed(in_word) < $signed(low_q)) begin
					low_q <= in_word;
				end
				if ($signed(in_word) > $signed(high_q)) begin
					high_q <= in_word;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q <= in_word;
		end
		if (cmd.prep) begin
			num_q <= s_q - low_q;
			rem_q <= s_q - low_q;
			div_q <= high_q - low_q;
			quo_q <= '0;
			sat_q <= (!is_flat && !is_below) ? GREY_MAX : '0;
			need_div_q <= status.need_div;
			flat_pre_q <= is_flat;
		end else if (cmd.step) begin
			rem_q <= rem_next;
			if (cmd.add_phase) begin
				quo_q <= quo_q + GREY_W'(carry);
			end else begin
				quo_q <= {quo_q[GREY_W-2:0], carry};
			end
		end
		if (cmd.wb) begin
			grey_q <= need_div_q ? quo_q : sat_q;
			flat_q <= flat_pre_q;
		end
	end

	assign grey = grey_q;
	assign flat = flat_q;

endmodule

### src/mmcs_check.sv
// port-level checks of the contrast stretch, bound to the top level
// depends on mmcs_pkg
module mmcs_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          operation,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [mmcs_pkg::GREY_W-1:0]   grey,
	input logic                          flat
);
	import mmcs_pkg::*;

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(grey) && $stable(flat))
		else $error("result changed while stalled");

	// flat range forces black
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat |-> grey == '0)
		else $error("flat result with nonzero grey");

	// a convert item occupies the block
	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_CONVERT) |=> !in_ready)
		else $error("ready right after convert item");

	// a measure item leaves the block ready
	a_measure_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_MEASURE) |=> in_ready)
		else $error("not ready after measure item");

endmodule

bind min_max_contrast_stretch mmcs_check u_check (.*);

### sim/tb.sv
// testbench for min_max_contrast_stretch: a directed list of measure and convert items,
// then random frames, each result checked against a predictor kept in step with the block
// or against the level listed with a directed item; depends on src/mmcs_pkg.sv and src/min_max_contrast_stretch.sv
module tb;
	import mmcs_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic                op;
		logic [SAMPLE_W-1:0] s;
		logic                f;
		bit                  typed;
		logic [GREY_W-1:0]   g;
		logic                fl;
	} stim_row_t;

	typedef struct {
		logic [GREY_W-1:0] g;
		logic              fl;
	} level_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                operation;
	logic [SAMPLE_W-1:0] sample;
	logic                first;
	logic                out_valid;
	logic                out_ready;
	logic [GREY_W-1:0]   grey;
	logic                flat;

	logic signed [SAMPLE_W-1:0] frame_min;
	logic signed [SAMPLE_W-1:0] frame_max;
	stim_row_t rows[$];
	level_t    levels_due[$];
	int        send_idle;
	int        recv_stall;
	int        items_sent;
	int        errors;
	int        cycles;

	min_max_contrast_stretch dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.sample(sample),
		.first(first),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.grey(grey),
		.flat(flat)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// running min/max and the stretched level of a convert item
	task automatic stretch_predict(input logic op, input logic [SAMPLE_W-1:0] s, input logic f,
			output bit has, output logic [GREY_W-1:0] g, output logic fl);
		logic signed [SAMPLE_W-1:0] v;
		longint num;
		longint span;
		v = s;
		has = 1'b0;
		g = '0;
		fl = 1'b0;
		if (op == OP_MEASURE) begin
			if (f) begin
				frame_min = v;
				frame_max = v;
			end else begin
				if (v < frame_min) frame_min = v;
				if (v > frame_max) frame_max = v;
			end
		end else begin
			has = 1'b1;
			if (frame_max <= frame_min) begin
				fl = 1'b1;
			end else if (v <= frame_min) begin
				g = '0;
			end else if (v >= frame_max) begin
				g = GREY_MAX;
			end else begin
				num = longint'(v) - longint'(frame_min);
				span = longint'(frame_max) - longint'(frame_min);
				g = GREY_W'((255 * num) / span);
			end
		end
	endtask

	task automatic push_item(input logic op, input logic [SAMPLE_W-1:0] s, input logic f,
			input bit typed, input logic [GREY_W-1:0] tg, input logic tf);
		bit has;
		logic [GREY_W-1:0] g;
		logic fl;
		level_t lv;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		sample <= s;
		first <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		stretch_predict(op, s, f, has, g, fl);
		if (has) begin
			if (typed) begin
				g = tg;
				fl = tf;
			end
			lv.g = g;
			lv.fl = fl;
			levels_due.push_back(lv);
		end
		items_sent++;
	endtask

	task automatic add_row(input logic op, input logic [SAMPLE_W-1:0] s, input logic f,
			input bit typed, input logic [GREY_W-1:0] g, input logic fl);
		stim_row_t r;
		r.op = op;
		r.s = s;
		r.f = f;
		r.typed = typed;
		r.g = g;
		r.fl = fl;
		rows.push_back(r);
	endtask

	function automatic logic [SAMPLE_W-1:0] near(input logic [SAMPLE_W-1:0] base,
			input int unsigned bits);
		logic [SAMPLE_W:0] mask;
		mask = (33'd1 << bits) - 33'd1;
		return base + (SAMPLE_W'($urandom) & mask[SAMPLE_W-1:0]);
	endfunction

	task automatic set_phase();
		case (items_sent * 4 / (RANDOM_ITEMS + rows.size()))
			0: begin
				send_idle = 0;
				recv_stall = 0;
			end
			1: begin
				send_idle = 54;
				recv_stall = 0;
			end
			2: begin
				send_idle = 0;
				recv_stall = 54;
			end
			default: begin
				send_idle = 38;
				recv_stall = 38;
			end
		endcase
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// result check
	always @(posedge clk) begin
		level_t lv;
		if (arst_n && out_valid && out_ready) begin
			if (levels_due.size() == 0) begin
				$display("%0t: unexpected item grey=%0d flat=%0b", $time, grey, flat);
				errors++;
			end else begin
				lv = levels_due.pop_front();
				if (grey !== lv.g) begin
					$display("%0t: grey expected %0d actual %0d", $time, lv.g, grey);
					errors++;
				end
				if (flat !== lv.fl) begin
					$display("%0t: flat expected %0b actual %0b", $time, lv.fl, flat);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL min_max_contrast_stretch");
			$finish;
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] base;
		int unsigned bits;
		int unsigned n;
		int unsigned kind;
		int target;
		logic [SAMPLE_W-1:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_MEASURE;
		sample = '0;
		first = 1'b0;
		out_ready = 1'b0;
		frame_min = '0;
		frame_max = '0;
		send_idle = 0;
		recv_stall = 0;
		items_sent = 0;
		errors = 0;
		cycles = 0;

		// convert before any measure, first ignored on convert
		add_row(OP_CONVERT, 32'h0000_0000, 1'b0, 1, 8'd0, 1'b1);
		add_row(OP_CONVERT, 32'h1234_5678, 1'b1, 1, 8'd0, 1'b1);
		// measure without first starts from zero
		add_row(OP_MEASURE, 32'h0064_0000, 1'b0, 0, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h0000_0000, 1'b0, 1, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h0064_0000, 1'b0, 1, 8'd255, 1'b0);
		add_row(OP_CONVERT, 32'h0032_0000, 1'b0, 0, 8'd0, 1'b0);
		// full signed range
		add_row(OP_MEASURE, 32'h8000_0000, 1'b1, 0, 8'd0, 1'b0);
		add_row(OP_MEASURE, 32'h7fff_ffff, 1'b0, 0, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h8000_0000, 1'b0, 1, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h7fff_ffff, 1'b0, 1, 8'd255, 1'b0);
		add_row(OP_CONVERT, 32'h0000_0000, 1'b0, 0, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'hffff_ffff, 1'b0, 0, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h8000_0001, 1'b1, 0, 8'd0, 1'b0);
		// zero range
		add_row(OP_MEASURE, 32'h0000_0005, 1'b1, 0, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h0000_0005, 1'b0, 1, 8'd0, 1'b1);
		add_row(OP_CONVERT, 32'h7fff_ffff, 1'b0, 1, 8'd0, 1'b1);
		add_row(OP_CONVERT, 32'h8000_0000, 1'b0, 1, 8'd0, 1'b1);
		// narrow range, samples outside it saturate
		add_row(OP_MEASURE, 32'h0000_0006, 1'b0, 0, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h0000_0004, 1'b0, 1, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h0000_0007, 1'b0, 1, 8'd255, 1'b0);
		add_row(OP_CONVERT, 32'h0000_0005, 1'b0, 1, 8'd0, 1'b0);
		// range of 256 steps
		add_row(OP_MEASURE, 32'h0001_0000, 1'b1, 0, 8'd0, 1'b0);
		add_row(OP_MEASURE, 32'h0001_0100, 1'b0, 0, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h0001_00ff, 1'b0, 0, 8'd0, 1'b0);
		add_row(OP_CONVERT, 32'h0001_0001, 1'b1, 0, 8'd0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			set_phase();
			push_item(rows[i].op, rows[i].s, rows[i].f, rows[i].typed, rows[i].g, rows[i].fl);
		end

		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			set_phase();
			kind = $urandom_range(9);
			if (kind == 0) begin
				// noise
				push_item(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)), 0, '0,
					1'b0);
			end else if (kind == 1) begin
				// flat frame
				v = $urandom;
				n = $urandom_range(3, 1);
				push_item(OP_MEASURE, v, 1'b1, 0, '0, 1'b0);
				repeat (n - 1) push_item(OP_MEASURE, v, 1'b0, 0, '0, 1'b0);
				n = $urandom_range(4, 1);
				repeat (n) push_item(OP_CONVERT, near(v, $urandom_range(2)),
					1'($urandom_range(1)), 0, '0, 1'b0);
			end else begin
				base = $urandom;
				bits = $urandom_range(32);
				n = $urandom_range(6, 1);
				for (int k = 0; k < n; k++) begin
					push_item(OP_MEASURE, near(base, bits),
						(k == 0) && ($urandom_range(9) != 0), 0, '0, 1'b0);
				end
				n = $urandom_range(8, 1);
				repeat (n) begin
					if ($urandom_range(4) == 0) begin
						v = near(base - (SAMPLE_W'(1) << (bits > 0 ? bits - 1 : 0)),
							(bits < 32) ? bits + 1 : 32);
					end else begin
						v = near(base, bits);
					end
					push_item(OP_CONVERT, v, $urandom_range(7) == 0, 0, '0, 1'b0);
				end
			end
		end
		in_valid <= 1'b0;

		while (levels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS min_max_contrast_stretch");
		end else begin
			$display("FAIL min_max_contrast_stretch");
		end
		$finish;
	end

endmodule

### min_max_contrast_stretch.f
src/mmcs_pkg.sv
src/mmcs_ctrl.sv
src/mmcs_datapath.sv
src/min_max_contrast_stretch.sv
src/mmcs_check.sv
sim/tb.sv
